// ===== rtl/ppdc_pkg.sv =====
// Shared types and constants for the position PID drive controller.
// No dependencies; every other file in rtl/ imports this package.
package ppdc_pkg;

    // Field widths
    localparam int POS_W      = 24;              // encoder and target width
    localparam int ERR_W      = POS_W + 2;       // error in half degrees
    localparam int DELTA_W    = ERR_W + 1;       // error difference
    localparam int INT_W      = 14;              // integral, 0.01 deg*s units
    localparam int TOL_W      = 10;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 12;              // Q4.12 gains
    localparam int DRIVE_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (POS_W > GAIN_W) ? POS_W : GAIN_W;  // widest register

    // Product widths (gain is zero-extended to a signed GAIN_W+1 operand)
    localparam int PP_W  = GAIN_W + 1 + ERR_W;
    localparam int PI_W  = GAIN_W + 1 + INT_W;
    localparam int PD_W  = GAIN_W + 1 + DELTA_W;
    localparam int NUM_W = PD_W + 14;            // room for the *5000 term and the sum
    localparam int MAG_W = NUM_W - 1;

    // Integral clamp
    localparam int INTEGRAL_LIMIT = 5000;

    // Output scaling: drive = round(num / (200 * 2^GAIN_FRAC)), saturated
    localparam int DRIVE_LIMIT = 100;
    localparam int DIV_BASE    = 200;
    localparam logic [MAG_W:0] ROUND_HALF = (MAG_W + 1)'(DIV_BASE) << (GAIN_FRAC - 1);
    localparam int T_W         = 15;             // quotient by 2^GAIN_FRAC, below SAT_T
    localparam int SAT_T       = (DRIVE_LIMIT + 1) * DIV_BASE;
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = 15;
    localparam logic [RECIP_W-1:0] RECIP_200 =
        RECIP_W'(((1 << RECIP_SHIFT) + DIV_BASE - 1) / DIV_BASE);
    localparam int Q_W         = 7;

    // Constant scale factors of the three PID terms
    localparam logic signed [NUM_W-1:0] SCALE_P = NUM_W'(100);
    localparam logic signed [NUM_W-1:0] SCALE_I = NUM_W'(2);
    localparam logic signed [NUM_W-1:0] SCALE_D = NUM_W'(5000);

    // Output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int CNT_W      = FIFO_AW + 1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET    = 3'd0,
        REG_TOLERANCE = 3'd1,
        REG_GAIN_P    = 3'd2,
        REG_GAIN_I    = 3'd3,
        REG_GAIN_D    = 3'd4
    } t_cfg_idx;

    // Request and response payloads
    typedef struct packed {
        logic signed [POS_W-1:0] left_position;
        logic signed [POS_W-1:0] right_position;
        logic                    start_move;
    } t_req;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive_percent;
        logic                      move_done;
    } t_rsp;

    // Between pipeline stages
    typedef struct packed {
        logic                      valid;
        logic                      done;
        logic signed [ERR_W-1:0]   e2;
        logic signed [DELTA_W-1:0] delta;
        logic signed [INT_W-1:0]   integral;
    } t_err_stage;

    typedef struct packed {
        logic                    valid;
        logic                    done;
        logic signed [PP_W-1:0]  pp;
        logic signed [PI_W-1:0]  pi;
        logic signed [PD_W-1:0]  pd;
    } t_prod_stage;

    typedef struct packed {
        logic                    valid;
        logic                    done;
        logic signed [NUM_W-1:0] sp;
        logic signed [NUM_W-1:0] si;
        logic signed [NUM_W-1:0] sd;
    } t_scaled_stage;

    typedef struct packed {
        logic           valid;
        logic           done;
        logic           neg;
        logic           sat;
        logic [T_W-1:0] t;
    } t_round_stage;

endpackage

// ===== rtl/ppdc_error.sv =====
// Error, done latch, integral and previous-error state of the controller.
// Depends on ppdc_pkg. Holds the only loop-carried state of the datapath.
module ppdc_error (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  ppdc_pkg::t_req                 i_req,
    input  logic signed [ppdc_pkg::POS_W-1:0] i_target,
    input  logic [ppdc_pkg::TOL_W-1:0]     i_tolerance,
    output ppdc_pkg::t_err_stage           o_stage
);
    import ppdc_pkg::*;

    logic signed [INT_W-1:0] r_integral, n_integral;
    logic signed [ERR_W-1:0] r_prev, n_prev;
    logic                    r_done, n_done;
    t_err_stage              r_stage, n_stage;

    logic signed [INT_W-1:0] eff_int;
    logic signed [ERR_W-1:0] eff_prev;
    logic                    eff_done;
    logic signed [ERR_W-1:0] e2;
    logic [ERR_W-1:0]        mag_e2;
    logic signed [ERR_W:0]   int_sum;
    logic signed [INT_W-1:0] int_clamped;
    logic                    compute;

    // Start clears the state before the tick is evaluated
    assign eff_int  = i_req.start_move ? '0 : r_integral;
    assign eff_prev = i_req.start_move ? '0 : r_prev;
    assign eff_done = i_req.start_move ? 1'b0 : r_done;

    // Error in half degrees: 2*target - (left + right)
    assign e2 = (ERR_W'(i_target) <<< 1) - (ERR_W'(i_req.left_position)
                + ERR_W'(i_req.right_position));
    assign mag_e2 = e2[ERR_W-1] ? ERR_W'(-e2) : ERR_W'(e2);

    // Integral step with clamp to +-INTEGRAL_LIMIT
    assign int_sum = (ERR_W+1)'(eff_int) + (ERR_W+1)'(e2);
    always_comb begin
        if (int_sum > (ERR_W+1)'(INTEGRAL_LIMIT)) begin
            int_clamped = INT_W'(INTEGRAL_LIMIT);
        end else if (int_sum < -(ERR_W+1)'(INTEGRAL_LIMIT)) begin
            int_clamped = -INT_W'(INTEGRAL_LIMIT);
        end else begin
            int_clamped = INT_W'(int_sum);
        end
    end

    // Done test and state update
    always_comb begin
        n_integral = eff_int;
        n_prev     = eff_prev;
        n_done     = eff_done;
        compute    = 1'b0;
        if (!eff_done) begin
            if (mag_e2 < {{(ERR_W-TOL_W-1){1'b0}}, i_tolerance, 1'b0}) begin
                n_done = 1'b1;
            end else begin
                compute    = 1'b1;
                n_integral = int_clamped;
                n_prev     = e2;
            end
        end
    end

    // Terms handed on are zero when no drive is computed, so the drive is zero
    always_comb begin
        n_stage.valid    = i_valid;
        n_stage.done     = n_done;
        n_stage.e2       = compute ? e2 : '0;
        n_stage.delta    = compute ? (DELTA_W'(e2) - DELTA_W'(eff_prev)) : '0;
        n_stage.integral = compute ? int_clamped : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_prev     <= '0;
            r_done     <= 1'b0;
            r_stage    <= '0;
        end else begin
            r_stage <= n_stage;
            if (i_valid) begin
                r_integral <= n_integral;
                r_prev     <= n_prev;
                r_done     <= n_done;
            end
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== rtl/ppdc_terms.sv =====
// Gain products and constant scaling of the three PID terms.
// Depends on ppdc_pkg. Two register stages: products, then scaled terms.
module ppdc_terms (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ppdc_pkg::t_err_stage          i_stage,
    input  logic [ppdc_pkg::GAIN_W-1:0]   i_gain_p,
    input  logic [ppdc_pkg::GAIN_W-1:0]   i_gain_i,
    input  logic [ppdc_pkg::GAIN_W-1:0]   i_gain_d,
    output ppdc_pkg::t_scaled_stage       o_stage
);
    import ppdc_pkg::*;

    t_prod_stage   r_prod, n_prod;
    t_scaled_stage r_scaled, n_scaled;

    logic signed [GAIN_W:0] gp_s, gi_s, gd_s;

    assign gp_s = $signed({1'b0, i_gain_p});
    assign gi_s = $signed({1'b0, i_gain_i});
    assign gd_s = $signed({1'b0, i_gain_d});

    // Gain products
    always_comb begin
        n_prod.valid = i_stage.valid;
        n_prod.done  = i_stage.done;
        n_prod.pp    = PP_W'(gp_s) * PP_W'(i_stage.e2);
        n_prod.pi    = PI_W'(gi_s) * PI_W'(i_stage.integral);
        n_prod.pd    = PD_W'(gd_s) * PD_W'(i_stage.delta);
    end

    // Constant scaling to a common denominator
    always_comb begin
        n_scaled.valid = r_prod.valid;
        n_scaled.done  = r_prod.done;
        n_scaled.sp    = NUM_W'(r_prod.pp) * SCALE_P;
        n_scaled.si    = NUM_W'(r_prod.pi) * SCALE_I;
        n_scaled.sd    = NUM_W'(r_prod.pd) * SCALE_D;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod   <= '0;
            r_scaled <= '0;
        end else begin
            r_prod   <= n_prod;
            r_scaled <= n_scaled;
        end
    end

    assign o_stage = r_scaled;

endmodule

// ===== rtl/ppdc_output.sv =====
// Sum, round-to-nearest division by 200*2^12 and saturation of the drive.
// Depends on ppdc_pkg. Two register stages; the last one feeds the output queue.
module ppdc_output (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ppdc_pkg::t_scaled_stage i_stage,
    output logic                    o_valid,
    output ppdc_pkg::t_rsp          o_rsp
);
    import ppdc_pkg::*;

    t_round_stage r_round, n_round;
    logic         r_valid;
    t_rsp         r_rsp, n_rsp;

    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]        num_neg;
    logic [MAG_W-1:0]        mag;
    logic [MAG_W:0]          rnd;
    logic [MAG_W-GAIN_FRAC:0] t_full;
    logic [T_W+RECIP_W-1:0]  prod;
    logic [Q_W-1:0]          q;

    // Sum and magnitude, rounding half away from zero
    assign num     = i_stage.sp + i_stage.si + i_stage.sd;
    assign num_neg = NUM_W'(-num);
    assign mag     = num[NUM_W-1] ? num_neg[MAG_W-1:0] : num[MAG_W-1:0];
    assign rnd     = {1'b0, mag} + ROUND_HALF;
    assign t_full  = rnd[MAG_W:GAIN_FRAC];

    always_comb begin
        n_round.valid = i_stage.valid;
        n_round.done  = i_stage.done;
        n_round.neg   = num[NUM_W-1];
        n_round.sat   = t_full >= (MAG_W - GAIN_FRAC + 1)'(SAT_T);
        n_round.t     = t_full[T_W-1:0];
    end

    // Divide by 200 through a reciprocal, then saturate and sign
    assign prod = (T_W+RECIP_W)'(r_round.t) * (T_W+RECIP_W)'(RECIP_200);
    assign q    = r_round.sat ? Q_W'(DRIVE_LIMIT) : prod[RECIP_SHIFT +: Q_W];

    always_comb begin
        n_rsp.drive_percent = r_round.neg ? -DRIVE_W'(q) : DRIVE_W'(q);
        n_rsp.move_done     = r_round.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round <= '0;
            r_valid <= 1'b0;
        end else begin
            r_round <= n_round;
            r_valid <= r_round.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ===== rtl/ppdc_fifo.sv =====
// Output queue that holds finished responses until the consumer takes them.
// Depends on ppdc_pkg. Always has room: the top level limits requests in flight.
module ppdc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  ppdc_pkg::t_rsp i_wr_data,
    input  logic           i_stall,
    output logic           o_valid,
    output ppdc_pkg::t_rsp o_data
);
    import ppdc_pkg::*;

    t_rsp               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               rd;

    assign o_valid = (r_count != '0);
    assign o_data  = mem[r_rd_ptr];
    assign rd      = o_valid && !i_stall;

    always_comb begin
        n_count = r_count;
        if (i_wr && !rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_wr && rd) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ===== rtl/position_pid_drive_controller.sv =====
// Position PID drive controller top level: configuration registers, input
// register, request credit count, pipeline and output queue. Depends on ppdc_pkg.
//
// One request per control tick carries both encoder positions and a start flag;
// each request yields exactly one response (drive percent and done flag). A new
// request is taken every clock cycle while o_stall is low. Each request passes
// through the input register, error/integral stage, gain products, constant
// scaling, sum and rounding, reciprocal divide, then the output queue. The error,
// integral and previous-error state closes its loop within the single error stage,
// so back-to-back requests see each other's updates. Up to eight requests may be
// outstanding; o_stall rises only when eight requests are outstanding, which needs
// the consumer to hold i_stall. Configuration takes effect for requests accepted
// after the write and should be changed only while no request is outstanding.
module position_pid_drive_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  ppdc_pkg::t_req                    i_req,
    // Response channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output ppdc_pkg::t_rsp                    o_rsp,
    // Configuration writes
    input  logic                              i_cfg_we,
    input  logic [ppdc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ppdc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ppdc_pkg::*;

    // Configuration registers
    logic signed [POS_W-1:0] r_target;
    logic [TOL_W-1:0]        r_tolerance;
    logic [GAIN_W-1:0]       r_gain_p, r_gain_i, r_gain_d;

    // Input register and outstanding request count
    logic             r_in_valid;
    t_req             r_in_req;
    logic [CNT_W-1:0] r_inflight, n_inflight;
    logic             req_acc, rsp_acc;

    t_err_stage    err_stage;
    t_scaled_stage scaled_stage;
    logic          res_valid;
    t_rsp          res_rsp;

    assign o_stall = (r_inflight == CNT_W'(FIFO_DEPTH));
    assign req_acc = i_valid && !o_stall;
    assign rsp_acc = o_valid && !i_stall;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_tolerance <= TOL_W'(10);
            r_gain_p    <= GAIN_W'(1638);
            r_gain_i    <= '0;
            r_gain_d    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TARGET:    r_target    <= $signed(i_cfg_data[POS_W-1:0]);
                REG_TOLERANCE: r_tolerance <= i_cfg_data[TOL_W-1:0];
                REG_GAIN_P:    r_gain_p    <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I:    r_gain_i    <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:    r_gain_d    <= i_cfg_data[GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    // Outstanding request count bounds the output queue
    always_comb begin
        n_inflight = r_inflight;
        if (req_acc && !rsp_acc) begin
            n_inflight = r_inflight + CNT_W'(1);
        end else if (!req_acc && rsp_acc) begin
            n_inflight = r_inflight - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_inflight <= '0;
        end else begin
            r_in_valid <= req_acc;
            r_inflight <= n_inflight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_in_req <= i_req;
        end
    end

    ppdc_error u_error (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_req       (r_in_req),
        .i_target    (r_target),
        .i_tolerance (r_tolerance),
        .o_stage     (err_stage)
    );

    ppdc_terms u_terms (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (err_stage),
        .i_gain_p (r_gain_p),
        .i_gain_i (r_gain_i),
        .i_gain_d (r_gain_d),
        .o_stage  (scaled_stage)
    );

    ppdc_output u_output (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (scaled_stage),
        .o_valid (res_valid),
        .o_rsp   (res_rsp)
    );

    ppdc_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (res_valid),
        .i_wr_data (res_rsp),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_data    (o_rsp)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for position_pid_drive_controller: directed and random
// control ticks, with a bit-accurate PID predictor checked against every response.
// Depends on ppdc_pkg and the controller RTL; reads no files.
`timescale 1ns / 1ps

module testbench;
    import ppdc_pkg::*;

    localparam int     POS_MAX         = (1 << (POS_W - 1)) - 1;
    localparam int     POS_MIN         = -(1 << (POS_W - 1));
    localparam int     TOL_RESET       = 10;
    localparam int     KP_RESET        = 1638;
    localparam int     GAIN_MAX        = (1 << GAIN_W) - 1;
    localparam int     TOL_MAX         = (1 << TOL_W) - 1;
    localparam longint INTEG_CLAMP     = 5000;
    localparam longint DRIVE_SAT       = 100;
    localparam longint DRIVE_DENOM     = longint'(200) << GAIN_FRAC;
    localparam int     RANDOM_PHASES   = 9;
    localparam int     TICKS_PER_PHASE = 200;
    localparam int     SETTLE_CYCLES   = 12;
    localparam int     WATCHDOG_LIMIT  = 2000;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_valid     = 1'b0;
    logic          o_stall;
    t_req          i_req       = '0;
    logic          o_valid;
    logic          i_stall     = 1'b0;
    t_rsp          o_rsp;
    logic          i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    position_pid_drive_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Controller shadow: registers and loop state, reset values at start
    logic signed [POS_W-1:0] model_target = '0;
    logic [TOL_W-1:0]        model_tol    = TOL_W'(TOL_RESET);
    logic [GAIN_W-1:0]       model_kp     = GAIN_W'(KP_RESET);
    logic [GAIN_W-1:0]       model_ki     = '0;
    logic [GAIN_W-1:0]       model_kd     = '0;
    logic signed [INT_W-1:0] integral_acc = '0;
    logic signed [ERR_W-1:0] last_error   = '0;
    logic                    move_latched = 1'b0;

    t_req tick_queue[$];
    t_rsp expected_drive[$];

    int  sender_idle_pct   = 32;
    int  receiver_idle_pct = 67;
    logic req_taken        = 1'b0;
    int  tick_count        = 0;
    int  drive_count       = 0;
    int  done_count        = 0;
    int  reg_writes        = 0;
    int  err_count         = 0;
    int  idle_cycles       = 0;

    // One control tick of the PID law; updates the shadow loop state
    function automatic t_rsp predict_drive(input t_req tick);
        longint left_pos, right_pos, tgt, tol, e2, mag_e2, delta, integ, num;
        longint kp, ki, kd, prev, drv;
        longint unsigned mag, quot;
        t_rsp rsp;
        left_pos  = $signed(tick.left_position);
        right_pos = $signed(tick.right_position);
        tgt       = $signed(model_target);
        tol       = model_tol;
        kp        = model_kp;
        ki        = model_ki;
        kd        = model_kd;
        drv       = 0;
        if (tick.start_move) begin
            integral_acc = '0;
            last_error   = '0;
            move_latched = 1'b0;
        end
        if (!move_latched) begin
            e2     = 2 * tgt - (left_pos + right_pos);
            mag_e2 = (e2 < 0) ? -e2 : e2;
            if (mag_e2 < 2 * tol) begin
                move_latched = 1'b1;
            end else begin
                integ = $signed(integral_acc);
                integ = integ + e2;
                if (integ > INTEG_CLAMP) integ = INTEG_CLAMP;
                if (integ < -INTEG_CLAMP) integ = -INTEG_CLAMP;
                integral_acc = integ[INT_W-1:0];
                prev  = $signed(last_error);
                delta = e2 - prev;
                num   = kp * e2 * 100 + ki * integ * 2 + kd * delta * 5000;
                mag   = (num < 0) ? -num : num;
                quot  = (mag + DRIVE_DENOM / 2) / DRIVE_DENOM;
                if (quot > DRIVE_SAT) quot = DRIVE_SAT;
                drv   = (num < 0) ? -longint'(quot) : longint'(quot);
                last_error = e2[ERR_W-1:0];
            end
        end
        rsp.drive_percent = drv[DRIVE_W-1:0];
        rsp.move_done     = move_latched;
        return rsp;
    endfunction

    function automatic longint clip_pos(input longint v);
        if (v > POS_MAX) return POS_MAX;
        if (v < POS_MIN) return POS_MIN;
        return v;
    endfunction

    task automatic push_tick(input longint left, input longint right, input bit start);
        t_req tick;
        tick.left_position  = left[POS_W-1:0];
        tick.right_position = right[POS_W-1:0];
        tick.start_move     = start;
        tick_queue.push_back(tick);
    endtask

    // Simulated plant closing in on the target, wheels slightly apart
    task automatic push_move(input int ticks, input bit with_start);
        longint tgt, pos, offset, skew;
        tgt    = $signed(model_target);
        offset = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1 << 22)
                                             : $urandom_range(0, 5000);
        pos    = $urandom_range(0, 1) ? tgt + offset : tgt - offset;
        for (int k = 0; k < ticks; k++) begin
            skew = longint'($urandom_range(0, 40)) - 20;
            push_tick(clip_pos(pos + skew), clip_pos(pos - skew), with_start && k == 0);
            pos = clip_pos(pos + ((tgt - pos) * longint'($urandom_range(2, 12))) / 8
                          + longint'($urandom_range(0, 4)) - 2);
        end
    endtask

    // Register write at the falling edge; shadow copy follows
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        reg_writes++;
        case (idx)
            REG_TARGET:    model_target = data[POS_W-1:0];
            REG_TOLERANCE: model_tol    = data[TOL_W-1:0];
            REG_GAIN_P:    model_kp     = data[GAIN_W-1:0];
            REG_GAIN_I:    model_ki     = data[GAIN_W-1:0];
            REG_GAIN_D:    model_kd     = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain(input int typical_max);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return GAIN_W'(GAIN_MAX);
            2:       return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(0, typical_max));
        endcase
    endfunction

    // New random setting; unused bits above the tolerance and gain registers carry noise
    task automatic randomize_regs(input bit touch_unused);
        logic [CFG_DATA_W-1:0] data;
        case ($urandom_range(0, 5))
            0:       data = CFG_DATA_W'(POS_MAX);
            1:       data = CFG_DATA_W'(POS_MIN);
            2:       data = CFG_DATA_W'($urandom);
            default: data = CFG_DATA_W'($urandom_range(0, 20000) - 10000);
        endcase
        write_reg(REG_TARGET, data);
        data = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 5))
            0:       data[TOL_W-1:0] = '0;
            1:       data[TOL_W-1:0] = TOL_W'(TOL_MAX);
            2:       data[TOL_W-1:0] = TOL_W'($urandom);
            default: data[TOL_W-1:0] = TOL_W'($urandom_range(1, 60));
        endcase
        write_reg(REG_TOLERANCE, data);
        data = CFG_DATA_W'($urandom);
        data[GAIN_W-1:0] = pick_gain(8192);
        write_reg(REG_GAIN_P, data);
        data = CFG_DATA_W'($urandom);
        data[GAIN_W-1:0] = pick_gain(2048);
        write_reg(REG_GAIN_I, data);
        data = CFG_DATA_W'($urandom);
        data[GAIN_W-1:0] = pick_gain(256);
        write_reg(REG_GAIN_D, data);
        // Indexes past the last register must not disturb anything
        if (touch_unused) begin
            for (int k = int'(REG_GAIN_D) + 1; k < (1 << CFG_IDX_W); k++) begin
                write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
            end
        end
    endtask

    // Wait until every request is answered, then let the pipeline settle
    task automatic drain();
        while (tick_queue.size() != 0 || expected_drive.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Request driver: new request only after the previous one was taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || req_taken) begin
                if (tick_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    i_req   <= tick_queue.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    // Monitor: check responses, predict accepted requests
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                drive_count++;
                if (o_rsp.move_done === 1'b1) done_count++;
                if (expected_drive.size() == 0) begin
                    $display("%0t: response with nothing outstanding: drive %0d done %b",
                             $time, o_rsp.drive_percent, o_rsp.move_done);
                    err_count++;
                end else begin
                    want = expected_drive.pop_front();
                    if (o_rsp.drive_percent !== want.drive_percent) begin
                        $display("%0t: drive_percent expected %0d actual %0d",
                                 $time, want.drive_percent, o_rsp.drive_percent);
                        err_count++;
                    end
                    if (o_rsp.move_done !== want.move_done) begin
                        $display("%0t: move_done expected %b actual %b",
                                 $time, want.move_done, o_rsp.move_done);
                        err_count++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                expected_drive.push_back(predict_drive(i_req));
                tick_count++;
            end
            req_taken <= i_valid && !o_stall;
        end else begin
            req_taken <= 1'b0;
        end
    end

    // Watchdog on cycles with no traffic at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no traffic for %0d cycles, %0d responses outstanding",
                     $time, idle_cycles, expected_drive.size());
            $display("[position_pid_drive_controller] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int queued, kind, len;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: saturation both ways, done latch and hold, restart
        push_tick(POS_MAX, POS_MAX, 1'b1);
        push_tick(POS_MIN, POS_MIN, 1'b0);
        push_tick(POS_MAX, POS_MIN, 1'b0);
        push_tick(POS_MIN, POS_MIN, 1'b0);
        push_tick(100, 100, 1'b1);
        push_tick(9, 9, 1'b0);
        push_tick(10, 10, 1'b1);
        push_tick(0, 0, 1'b1);
        drain();

        // Full gains, zero tolerance, target at the top: clamps and derivative
        write_reg(REG_TARGET, CFG_DATA_W'(POS_MAX));
        write_reg(REG_TOLERANCE, '0);
        write_reg(REG_GAIN_P, CFG_DATA_W'(GAIN_MAX));
        write_reg(REG_GAIN_I, CFG_DATA_W'(GAIN_MAX));
        write_reg(REG_GAIN_D, CFG_DATA_W'(GAIN_MAX));
        push_tick(POS_MAX, POS_MAX, 1'b1);
        push_tick(POS_MIN, POS_MIN, 1'b0);
        push_tick(POS_MAX - 1, POS_MAX - 1, 1'b0);
        push_tick(POS_MAX, POS_MAX, 1'b0);
        drain();

        // Integral only, widest tolerance, target at the bottom: band edge
        write_reg(REG_TARGET, CFG_DATA_W'(POS_MIN));
        write_reg(REG_TOLERANCE, CFG_DATA_W'(TOL_MAX));
        write_reg(REG_GAIN_P, '0);
        write_reg(REG_GAIN_I, CFG_DATA_W'(4096));
        write_reg(REG_GAIN_D, '0);
        push_tick(POS_MAX, POS_MAX, 1'b1);
        push_tick(POS_MIN, POS_MIN, 1'b0);
        push_tick(POS_MIN, POS_MIN + 2 * TOL_MAX, 1'b1);
        push_tick(POS_MIN, POS_MIN + 2 * TOL_MAX - 1, 1'b0);
        drain();

        // Unity proportional gain: half-percent ties round away from zero
        write_reg(REG_TARGET, '0);
        write_reg(REG_TOLERANCE, CFG_DATA_W'(TOL_RESET));
        write_reg(REG_GAIN_P, CFG_DATA_W'(4096));
        write_reg(REG_GAIN_I, '0);
        push_tick(-10, -11, 1'b1);
        push_tick(10, 11, 1'b1);
        push_tick(-100, -100, 1'b1);
        push_tick(-101, -100, 1'b0);
        drain();

        // Random settings, mostly well-formed moves plus noise and headless moves
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == RANDOM_PHASES / 3) begin
                sender_idle_pct   = 67;
                receiver_idle_pct = 32;
            end else if (phase == 2 * RANDOM_PHASES / 3) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            randomize_regs(phase == 0 || $urandom_range(0, 2) == 0);
            queued = 0;
            while (queued < TICKS_PER_PHASE) begin
                kind = $urandom_range(0, 9);
                if (kind < 7) begin
                    len = $urandom_range(4, 40);
                    push_move(len, 1'b1);
                end else if (kind < 9) begin
                    len = $urandom_range(1, 5);
                    repeat (len) push_tick($urandom, $urandom, $urandom_range(0, 7) == 0);
                end else begin
                    len = $urandom_range(2, 12);
                    push_move(len, 1'b0);
                end
                queued += len;
            end
            drain();
        end

        $display("Run covered %0d control ticks and %0d responses (%0d with the move done)",
                 tick_count, drive_count, done_count);
        $display("across %0d register writes, %0d mismatches", reg_writes, err_count);
        if (err_count == 0 && expected_drive.size() == 0) begin
            $display("[position_pid_drive_controller] OK");
        end else begin
            $display("[position_pid_drive_controller] ERROR");
        end
        $finish;
    end

endmodule
